// ----- src/isf_pkg.sv -----
// Shared types and constants for the three-lobe interrupted sinusoidal projection.
// Holds the CORDIC rotation state type, the arctangent table and the pi/60 constant function.
// No dependencies.
`default_nettype none

package isf_pkg;

    localparam int CF           = 30;   // cosine fraction bits
    localparam int RW           = 34;   // rotation datapath width
    localparam int CORDIC_STEPS = 30;

    localparam logic signed [RW-1:0] CORDIC_GAIN_INV = 34'sh0_26DD_3B6A;

    localparam logic [63:0] PI_Q60  = 64'h3243_F6A8_885A_308D;
    localparam logic [63:0] PI_STEP = PI_Q60 / 64'd60;

    localparam logic [31:0] ATAN_TAB [CORDIC_STEPS] = '{
        32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
        32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
        32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
        32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
        32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
        32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002
    };

    typedef struct packed {
        logic signed [RW-1:0] x;
        logic signed [RW-1:0] y;
        logic signed [RW-1:0] z;
    } t_rot;

    typedef struct packed {
        logic live;     // an item occupies this stage
        logic pvalid;   // point inside the defined range
    } t_ctl;

    // n * pi/60 at frac fraction bits, rounded to nearest, half up on the magnitude
    function automatic logic signed [63:0] pi60(input int n, input int frac);
        logic [63:0] m;
        logic [63:0] r;
        int          s;
        s = 60 - frac;
        m = 64'((n < 0) ? -n : n) * PI_STEP;
        r = (m + (64'd1 << (s - 1))) >> s;
        return (n < 0) ? -$signed(r) : $signed(r);
    endfunction

endpackage

`default_nettype wire

// ----- src/isf_front.sv -----
// Input stage: range check, lobe selection and CORDIC seed for one point per cycle.
// Depends on isf_pkg.
`default_nettype none

module isf_front #(
    parameter int ANGLE_WIDTH     = 32,
    parameter int ANGLE_FRAC_BITS = 28
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_take,
    input  wire  signed [ANGLE_WIDTH-1:0]      i_latitude,
    input  wire  signed [ANGLE_WIDTH-1:0]      i_longitude,
    output isf_pkg::t_ctl                      o_ctl,
    output isf_pkg::t_rot                      o_rot,
    output logic signed [ANGLE_WIDTH-1:0]      o_lat,
    output logic signed [ANGLE_WIDTH:0]        o_diff,
    output logic signed [ANGLE_WIDTH-1:0]      o_centre
);
    import isf_pkg::*;

    localparam logic signed [63:0] HALF_PI = pi60(30, ANGLE_FRAC_BITS);
    localparam logic signed [63:0] PI      = pi60(60, ANGLE_FRAC_BITS);
    localparam logic signed [63:0] B_WEST  = pi60(-6, ANGLE_FRAC_BITS);
    localparam logic signed [63:0] B_EAST  = pi60(20, ANGLE_FRAC_BITS);
    localparam logic signed [63:0] C_WEST  = pi60(-33, ANGLE_FRAC_BITS);
    localparam logic signed [63:0] C_MID   = pi60(7, ANGLE_FRAC_BITS);
    localparam logic signed [63:0] C_EAST  = pi60(40, ANGLE_FRAC_BITS);

    logic signed [63:0] lat64;
    logic signed [63:0] lon64;
    logic signed [63:0] zq;
    logic signed [63:0] cen64;
    logic signed [63:0] diff64;
    logic               in_range;

    t_ctl                         r_ctl;
    t_rot                         r_rot;
    logic signed [ANGLE_WIDTH-1:0] r_lat;
    logic signed [ANGLE_WIDTH:0]   r_diff;
    logic signed [ANGLE_WIDTH-1:0] r_centre;

    assign lat64 = 64'(i_latitude);
    assign lon64 = 64'(i_longitude);

    // latitude to 30 fraction bits: floor shift right, or exact shift left
    generate
        if (ANGLE_FRAC_BITS >= CF) begin : g_shr
            assign zq = lat64 >>> (ANGLE_FRAC_BITS - CF);
        end else begin : g_shl
            assign zq = lat64 <<< (CF - ANGLE_FRAC_BITS);
        end
    endgenerate

    assign in_range = (lat64 <= HALF_PI) && (lat64 >= -HALF_PI) &&
                      (lon64 <= PI) && (lon64 >= -PI);

    always_comb begin
        if (lon64 < B_WEST) begin
            cen64 = C_WEST;
        end else if (lon64 < B_EAST) begin
            cen64 = C_MID;
        end else begin
            cen64 = C_EAST;
        end
        diff64 = lon64 - cen64;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl.live   <= i_take;
            // valid flag only rides with a live transfer
            r_ctl.pvalid <= i_take && in_range;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rot.x  <= CORDIC_GAIN_INV;
        r_rot.y  <= '0;
        r_rot.z  <= zq[RW-1:0];
        r_lat    <= i_latitude;
        r_diff   <= diff64[ANGLE_WIDTH:0];
        r_centre <= cen64[ANGLE_WIDTH-1:0];
    end

    assign o_ctl    = r_ctl;
    assign o_rot    = r_rot;
    assign o_lat    = r_lat;
    assign o_diff   = r_diff;
    assign o_centre = r_centre;

endmodule

`default_nettype wire

// ----- src/isf_cordic_cell.sv -----
// One CORDIC rotation iteration as a registered cell of the chain.
// Carries the item's side data along unchanged. Depends on isf_pkg.
`default_nettype none

module isf_cordic_cell #(
    parameter int STEP   = 0,
    parameter int SIDE_W = 8
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  isf_pkg::t_ctl       i_ctl,
    input  isf_pkg::t_rot       i_rot,
    input  wire  [SIDE_W-1:0]   i_side,
    output isf_pkg::t_ctl       o_ctl,
    output isf_pkg::t_rot       o_rot,
    output logic [SIDE_W-1:0]   o_side
);
    import isf_pkg::*;

    localparam logic signed [RW-1:0] ANGLE = RW'(ATAN_TAB[STEP]);

    logic signed [RW-1:0] dx;
    logic signed [RW-1:0] dy;
    t_rot                 n_rot;
    t_ctl                 r_ctl;
    t_rot                 r_rot;
    logic [SIDE_W-1:0]    r_side;

    assign dx = i_rot.y >>> STEP;
    assign dy = i_rot.x >>> STEP;

    always_comb begin
        if (!i_rot.z[RW-1]) begin
            n_rot.x = i_rot.x - dx;
            n_rot.y = i_rot.y + dy;
            n_rot.z = i_rot.z - ANGLE;
        end else begin
            n_rot.x = i_rot.x + dx;
            n_rot.y = i_rot.y - dy;
            n_rot.z = i_rot.z + ANGLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rot  <= n_rot;
        r_side <= i_side;
    end

    assign o_ctl  = r_ctl;
    assign o_rot  = r_rot;
    assign o_side = r_side;

endmodule

`default_nettype wire

// ----- src/isf_scale.sv -----
// Back end: cosine clamp, scaled offset from the lobe centre, saturation.
// Four register stages; multiply split in two partial products. Depends on isf_pkg.
`default_nettype none

module isf_scale #(
    parameter int ANGLE_WIDTH = 32
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  isf_pkg::t_ctl                      i_ctl,
    input  wire  signed [isf_pkg::RW-1:0]      i_cos,
    input  wire  signed [ANGLE_WIDTH-1:0]      i_lat,
    input  wire  signed [ANGLE_WIDTH:0]        i_diff,
    input  wire  signed [ANGLE_WIDTH-1:0]      i_centre,
    output logic                               o_strobe,
    output logic signed [ANGLE_WIDTH-1:0]      o_east_coord,
    output logic signed [ANGLE_WIDTH-1:0]      o_north_coord,
    output logic                               o_point_valid
);
    import isf_pkg::*;

    localparam int W  = ANGLE_WIDTH;
    localparam int XW = ANGLE_WIDTH + 4;
    localparam logic [CF:0]   COS_ONE = (CF+1)'(1) << CF;
    localparam logic [47:0]   RND     = 48'd1 << (CF - 1);
    localparam logic signed [W-1:0] SAT_MAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] SAT_MIN = {1'b1, {(W-1){1'b0}}};

    // stage 1
    t_ctl                 r1_ctl;
    logic [CF:0]          r1_c;
    logic [W:0]           r1_mag;
    logic                 r1_neg;
    logic signed [W-1:0]  r1_cen;
    logic signed [W-1:0]  r1_lat;
    logic [CF:0]          n1_c;
    logic [W:0]           n1_mag;

    // stage 2
    t_ctl                 r2_ctl;
    logic [W+15:0]        r2_a;
    logic [47:0]          r2_b;
    logic                 r2_neg;
    logic signed [W-1:0]  r2_cen;
    logic signed [W-1:0]  r2_lat;

    // stage 3
    t_ctl                 r3_ctl;
    logic [W+2:0]         r3_r;
    logic                 r3_neg;
    logic signed [W-1:0]  r3_cen;
    logic signed [W-1:0]  r3_lat;
    logic [W+16:0]        n3_sum;

    // stage 4
    t_ctl                 r4_ctl;
    logic signed [W-1:0]  r4_east;
    logic signed [W-1:0]  r4_north;
    logic signed [XW-1:0] n4_x;
    logic signed [XW-1:0] cen_x;
    logic signed [XW-1:0] mag_x;
    logic signed [W-1:0]  n4_sat;
    logic                 n4_ovf;

    always_comb begin
        if (i_cos[RW-1]) begin
            n1_c = '0;
        end else if (i_cos > $signed(RW'(COS_ONE))) begin
            n1_c = COS_ONE;
        end else begin
            n1_c = i_cos[CF:0];
        end
        n1_mag = i_diff[W] ? (W+1)'(-i_diff) : i_diff;
    end

    assign n3_sum = {1'b0, r2_a} + (W+17)'(r2_b[47:16]);

    assign cen_x  = XW'(r3_cen);
    assign mag_x  = {1'b0, r3_r};
    assign n4_x   = r3_neg ? (cen_x - mag_x) : (cen_x + mag_x);
    // top bits must all match the sign bit of the narrow result
    assign n4_ovf = (n4_x[XW-1:W-1] != {(XW-W+1){1'b0}}) &&
                    (n4_x[XW-1:W-1] != {(XW-W+1){1'b1}});
    assign n4_sat = n4_ovf ? (n4_x[XW-1] ? SAT_MIN : SAT_MAX) : n4_x[W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_ctl <= '0;
            r2_ctl <= '0;
            r3_ctl <= '0;
            r4_ctl <= '0;
        end else begin
            r1_ctl <= i_ctl;
            r2_ctl <= r1_ctl;
            r3_ctl <= r2_ctl;
            r4_ctl <= r3_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_c     <= n1_c;
        r1_mag   <= n1_mag;
        r1_neg   <= i_diff[W];
        r1_cen   <= i_centre;
        r1_lat   <= i_lat;

        r2_a     <= (W+16)'(r1_mag[W:16]) * (W+16)'(r1_c);
        r2_b     <= 48'(r1_mag[15:0]) * 48'(r1_c) + RND;
        r2_neg   <= r1_neg;
        r2_cen   <= r1_cen;
        r2_lat   <= r1_lat;

        r3_r     <= n3_sum[W+16:14];
        r3_neg   <= r2_neg;
        r3_cen   <= r2_cen;
        r3_lat   <= r2_lat;

        r4_east  <= r3_ctl.pvalid ? n4_sat : '0;
        r4_north <= r3_ctl.pvalid ? r3_lat : '0;
    end

    assign o_strobe      = r4_ctl.live;
    assign o_point_valid = r4_ctl.pvalid;
    assign o_east_coord  = r4_east;
    assign o_north_coord = r4_north;

endmodule

`default_nettype wire

// ----- src/interrupted_sinusoidal_forward.sv -----
// Top level of the three-lobe interrupted sinusoidal forward projection.
// Instantiates isf_front, a chain of isf_cordic_cell and isf_scale; uses isf_pkg.
//
// Usage:
//   Raise start with a latitude and longitude (radians, signed fixed point with
//   ANGLE_FRAC_BITS fraction bits). A transfer happens at each clock edge with
//   start high and busy low; busy is never raised, so a new point may be given
//   in every cycle.
//   Each point yields one result, shown for exactly one cycle with o_strobe
//   high: o_east_coord, o_north_coord and o_point_valid. A point with
//   |latitude| > pi/2 or |longitude| > pi gives o_point_valid low and both
//   coordinates zero.
//   From transfer to strobe a point passes one input stage, one cell per
//   CORDIC iteration (30 cells), and four stages for the scaled offset
//   from the lobe centre. Throughput is one point per cycle.
//   Results leave in transfer order; the receiver cannot stall the output.
//   Synchronous reset clears all stage-occupancy flags; items in flight are
//   dropped and no strobe follows until new points are given.
`default_nettype none

module interrupted_sinusoidal_forward #(
    parameter int ANGLE_WIDTH     = 32,
    parameter int ANGLE_FRAC_BITS = 28
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            start,
    output logic                           busy,
    input  wire  signed [ANGLE_WIDTH-1:0]  i_latitude,
    input  wire  signed [ANGLE_WIDTH-1:0]  i_longitude,
    output logic                           o_strobe,
    output logic signed [ANGLE_WIDTH-1:0]  o_east_coord,
    output logic signed [ANGLE_WIDTH-1:0]  o_north_coord,
    output logic                           o_point_valid
);
    import isf_pkg::*;

    localparam int W       = ANGLE_WIDTH;
    localparam int SIDE_W  = 3 * W + 1;
    localparam int LATENCY = CORDIC_STEPS + 5;

    t_ctl                ctl  [CORDIC_STEPS+1];
    t_rot                rot  [CORDIC_STEPS+1];
    logic [SIDE_W-1:0]   side [CORDIC_STEPS+1];

    logic signed [W-1:0] f_lat;
    logic signed [W:0]   f_diff;
    logic signed [W-1:0] f_centre;
    logic signed [W-1:0] c_lat;
    logic signed [W:0]   c_diff;
    logic signed [W-1:0] c_centre;

    assign busy = 1'b0;

    isf_front #(
        .ANGLE_WIDTH     (ANGLE_WIDTH),
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (start && !busy),
        .i_latitude  (i_latitude),
        .i_longitude (i_longitude),
        .o_ctl       (ctl[0]),
        .o_rot       (rot[0]),
        .o_lat       (f_lat),
        .o_diff      (f_diff),
        .o_centre    (f_centre)
    );

    assign side[0] = {f_lat, f_diff, f_centre};

    generate
        for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
            isf_cordic_cell #(
                .STEP   (i),
                .SIDE_W (SIDE_W)
            ) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctl   (ctl[i]),
                .i_rot   (rot[i]),
                .i_side  (side[i]),
                .o_ctl   (ctl[i+1]),
                .o_rot   (rot[i+1]),
                .o_side  (side[i+1])
            );
        end
    endgenerate

    assign {c_lat, c_diff, c_centre} = side[CORDIC_STEPS];

    isf_scale #(
        .ANGLE_WIDTH (ANGLE_WIDTH)
    ) u_scale (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (ctl[CORDIC_STEPS]),
        .i_cos         (rot[CORDIC_STEPS].x),
        .i_lat         (c_lat),
        .i_diff        (c_diff),
        .i_centre      (c_centre),
        .o_strobe      (o_strobe),
        .o_east_coord  (o_east_coord),
        .o_north_coord (o_north_coord),
        .o_point_valid (o_point_valid)
    );

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LATENCY o_strobe)
        else $error("result strobe missing after transfer");

    a_north_passes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_point_valid) |-> (o_north_coord == $past(i_latitude, LATENCY)))
        else $error("north coordinate differs from transferred latitude");

    a_valid_needs_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_strobe |-> !o_point_valid)
        else $error("point valid without result strobe");

endmodule

`default_nettype wire

// ----- dv/isf_projection_check.sv -----
// Result checker for the three-lobe interrupted sinusoidal forward projection.
// Watches the start/busy and strobe channels, predicts each projected point, compares fields.
// No dependencies; instantiated by interrupted_sinusoidal_forward_test.
module isf_projection_check #(
    parameter int ANGLE_WIDTH     = 32,
    parameter int ANGLE_FRAC_BITS = 28
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_start,
    input  wire                    i_busy,
    input  wire [ANGLE_WIDTH-1:0]  i_latitude,
    input  wire [ANGLE_WIDTH-1:0]  i_longitude,
    input  wire                    i_strobe,
    input  wire [ANGLE_WIDTH-1:0]  i_east_coord,
    input  wire [ANGLE_WIDTH-1:0]  i_north_coord,
    input  wire                    i_point_valid,
    output int                     o_mismatches,
    output int                     o_pending,
    output int                     o_results,
    output int                     o_undefined
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int W = ANGLE_WIDTH;
    localparam int F = ANGLE_FRAC_BITS;

    localparam logic [63:0] PI_STEP = 64'h3243_F6A8_885A_308D / 64'd60;

    // atan(2^-i) at 30 fraction bits
    localparam logic [31:0] ATAN_Q30 [30] = '{
        32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
        32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
        32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
        32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
        32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
        32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002
    };

    typedef struct packed {
        logic [W-1:0] east;
        logic [W-1:0] north;
        logic         valid;
    } point_result_t;

    point_result_t points_in_flight[$];
    int            mismatch_total;
    int            result_total;
    int            undefined_total;

    // n * pi/60 at F fraction bits, nearest with half up on the magnitude
    function automatic longint pi_multiple(input int n);
        logic [63:0] m;
        logic [63:0] r;
        m = 64'((n < 0) ? -n : n) * PI_STEP;
        r = (m + (64'd1 << (59 - F))) >> (60 - F);
        return (n < 0) ? -longint'(r) : longint'(r);
    endfunction

    // rotation-mode CORDIC, cosine at 30 fraction bits
    function automatic longint cos_q30(input longint phi);
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        x = 'h26DD3B6A;
        y = 0;
        if (F >= 30) begin
            z = phi >>> (F - 30);
        end else begin
            z = phi <<< (30 - F);
        end
        for (int i = 0; i < 30; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x = x - dx;
                y = y + dy;
                z = z - longint'(ATAN_Q30[i]);
            end else begin
                x = x + dx;
                y = y - dy;
                z = z + longint'(ATAN_Q30[i]);
            end
        end
        if (x < 0) x = 0;
        if (x > (longint'(1) <<< 30)) x = longint'(1) <<< 30;
        return x;
    endfunction

    function automatic point_result_t project_point(input logic signed [W-1:0] lat,
                                                    input logic signed [W-1:0] lon);
        longint        phi;
        longint        lam;
        longint        centre;
        longint        d;
        longint        x;
        longint        hi;
        longint        lo;
        logic [63:0]   mag;
        logic [63:0]   c;
        logic [63:0]   a;
        logic [63:0]   b;
        logic [63:0]   r;
        point_result_t p;
        phi = lat;
        lam = lon;
        p   = '0;
        if (phi > pi_multiple(30) || phi < -pi_multiple(30) ||
            lam > pi_multiple(60) || lam < -pi_multiple(60)) begin
            return p;
        end
        if (lam < pi_multiple(-6)) begin
            centre = pi_multiple(-33);
        end else if (lam < pi_multiple(20)) begin
            centre = pi_multiple(7);
        end else begin
            centre = pi_multiple(40);
        end
        d   = lam - centre;
        mag = (d < 0) ? -d : d;
        c   = cos_q30(phi);
        // split product keeps the rounding of |d| * cos / 2^30 exact
        a   = (mag >> 16) * c;
        b   = (mag & 64'hFFFF) * c + (64'd1 << 29);
        r   = (a + (b >> 16)) >> 14;
        x   = ((d < 0) ? -longint'(r) : longint'(r)) + centre;
        hi  = (longint'(1) <<< (W - 1)) - 1;
        lo  = -hi - 1;
        if (x > hi) x = hi;
        if (x < lo) x = lo;
        p.east  = x[W-1:0];
        p.north = lat;
        p.valid = 1'b1;
        return p;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t ns: mismatch on %s: got %h, expected %h", $time, what, got, want);
        mismatch_total++;
    endtask

    always @(posedge i_clk) begin
        point_result_t want;
        if (!i_rst_n) begin
            points_in_flight.delete();
            mismatch_total  = 0;
            result_total    = 0;
            undefined_total = 0;
        end else begin
            // results leave before the point accepted at this same edge can count
            if (i_strobe) begin
                result_total++;
                if (points_in_flight.size() == 0) begin
                    report_mismatch("strobe with no point in flight", i_east_coord, '0);
                end else begin
                    want = points_in_flight.pop_front();
                    if (!want.valid) undefined_total++;
                    if (i_east_coord !== want.east)
                        report_mismatch("east_coord", i_east_coord, want.east);
                    if (i_north_coord !== want.north)
                        report_mismatch("north_coord", i_north_coord, want.north);
                    if (i_point_valid !== want.valid)
                        report_mismatch("point_valid", i_point_valid, want.valid);
                end
            end
            if (i_start && !i_busy) begin
                points_in_flight.push_back(project_point(i_latitude, i_longitude));
            end
        end
        o_mismatches <= mismatch_total;
        o_pending    <= points_in_flight.size();
        o_results    <= result_total;
        o_undefined  <= undefined_total;
    end

endmodule

// ----- dv/interrupted_sinusoidal_forward_test.sv -----
// Testbench top for the three-lobe interrupted sinusoidal forward projection.
// Drives directed and random points into interrupted_sinusoidal_forward; checking is done
// by isf_projection_check, which reports its mismatch count back here for the verdict.
module interrupted_sinusoidal_forward_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ANGLE_WIDTH     = 32;
    localparam int ANGLE_FRAC_BITS = 28;
    localparam int RANDOM_POINTS   = 430;
    localparam int CALM_TAIL       = 60;
    localparam int WATCHDOG_LIMIT  = 1000;
    localparam int SETTLE_CYCLES   = 40;

    localparam logic [63:0] PI_STEP = 64'h3243_F6A8_885A_308D / 64'd60;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n;
    logic                    start;
    logic                    busy;
    logic [ANGLE_WIDTH-1:0]  i_latitude;
    logic [ANGLE_WIDTH-1:0]  i_longitude;
    logic                    o_strobe;
    logic [ANGLE_WIDTH-1:0]  o_east_coord;
    logic [ANGLE_WIDTH-1:0]  o_north_coord;
    logic                    o_point_valid;

    int mismatches;
    int pending;
    int results;
    int undefined_points;
    int idle_cycles;
    bit bursty;

    int half_pi;
    int full_pi;
    int west_edge;
    int east_edge;
    int centre_west;
    int centre_mid;
    int centre_east;

    interrupted_sinusoidal_forward #(
        .ANGLE_WIDTH     (ANGLE_WIDTH),
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_latitude    (i_latitude),
        .i_longitude   (i_longitude),
        .o_strobe      (o_strobe),
        .o_east_coord  (o_east_coord),
        .o_north_coord (o_north_coord),
        .o_point_valid (o_point_valid)
    );

    isf_projection_check #(
        .ANGLE_WIDTH     (ANGLE_WIDTH),
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
    ) projection_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_busy        (busy),
        .i_latitude    (i_latitude),
        .i_longitude   (i_longitude),
        .i_strobe      (o_strobe),
        .i_east_coord  (o_east_coord),
        .i_north_coord (o_north_coord),
        .i_point_valid (o_point_valid),
        .o_mismatches  (mismatches),
        .o_pending     (pending),
        .o_results     (results),
        .o_undefined   (undefined_points)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // stimulus angles at the block's boundaries: n * pi/60, nearest
    function automatic int angle_sixtieths(input int n);
        logic [63:0] m;
        logic [63:0] r;
        m = 64'((n < 0) ? -n : n) * PI_STEP;
        r = (m + (64'd1 << (59 - ANGLE_FRAC_BITS))) >> (60 - ANGLE_FRAC_BITS);
        return (n < 0) ? -int'(r) : int'(r);
    endfunction

    function automatic int near(input int base);
        return base + int'($urandom_range(16)) - 8;
    endfunction

    function automatic int either_sign(input int v);
        return $urandom_range(1) ? v : -v;
    endfunction

    task automatic offer_point(input int lat, input int lon);
        start       <= 1'b1;
        i_latitude  <= lat;
        i_longitude <= lon;
        do @(posedge i_clk); while (busy);
        if (bursty && $urandom_range(2) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(8, 1)) @(posedge i_clk);
        end
    endtask

    task automatic drain_results;
        start <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    always @(posedge i_clk) begin
        if ((start && !busy) || o_strobe) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) @(posedge i_clk);
        $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin : stimulus
        int lat;
        int lon;
        int pick;
        start       = 1'b0;
        i_latitude  = '0;
        i_longitude = '0;
        i_rst_n     = 1'b0;
        bursty      = 1'b0;
        half_pi     = angle_sixtieths(30);
        full_pi     = angle_sixtieths(60);
        west_edge   = angle_sixtieths(-6);
        east_edge   = angle_sixtieths(20);
        centre_west = angle_sixtieths(-33);
        centre_mid  = angle_sixtieths(7);
        centre_east = angle_sixtieths(40);
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: range limits, lobe boundaries, centres, raw extremes
        offer_point(0, 0);
        offer_point(half_pi, 0);
        offer_point(-half_pi, 0);
        offer_point(half_pi + 1, 0);
        offer_point(-half_pi - 1, 0);
        offer_point(0, full_pi);
        offer_point(0, -full_pi);
        offer_point(0, full_pi + 1);
        offer_point(0, -full_pi - 1);
        offer_point(half_pi, full_pi);
        offer_point(-half_pi, -full_pi);
        bursty = 1'b1;
        offer_point(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        offer_point(32'h8000_0000, 32'h8000_0000);
        offer_point(-1, -1);
        offer_point(32'h1000_0000, west_edge - 1);
        offer_point(32'h1000_0000, west_edge);
        offer_point(-32'h1000_0000, east_edge - 1);
        offer_point(-32'h1000_0000, east_edge);
        offer_point(32'h0F00_0000, centre_west);
        offer_point(32'h0F00_0000, centre_mid);
        offer_point(32'h0F00_0000, centre_east);
        offer_point(32'h5555_5555, 32'hAAAA_AAAA);
        offer_point(32'h1555_5555, -32'h2AAA_AAAA);

        for (int n = 0; n < RANDOM_POINTS; n++) begin
            if (n % 50 == 0) bursty = $urandom_range(1);
            if (n >= RANDOM_POINTS - CALM_TAIL) bursty = 1'b0;
            if (n == RANDOM_POINTS / 2) drain_results();
            lat  = int'($urandom_range(2 * half_pi)) - half_pi;
            lon  = int'($urandom_range(2 * full_pi)) - full_pi;
            pick = $urandom_range(99);
            if (pick >= 90) begin
                lat = $urandom;
                lon = $urandom;
            end else if (pick >= 60) begin
                case ($urandom_range(5))
                    0: lat = either_sign(near(half_pi));
                    1: lon = either_sign(near(full_pi));
                    2: lon = near(west_edge);
                    3: lon = near(east_edge);
                    4: lon = near($urandom_range(1) ? centre_mid :
                                  ($urandom_range(1) ? centre_west : centre_east));
                    default: begin
                        lat = either_sign(near(half_pi));
                        lon = either_sign(near(full_pi));
                    end
                endcase
            end
            offer_point(lat, lon);
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("covered %0d projected points, %0d of them outside the defined range,",
                 results, undefined_points);
        $display("across all three lobes, with random input gaps and one full drain mid-run");
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
